>>> hdl/vsl_pkg.sv
// Shared types, constants and helpers for the velocity slew limiter.
// Used by vsl_lane, vsl_rsp_buf and velocity_slew_limiter_core; no dependencies.
`timescale 1ns / 1ps

package vsl_pkg;

   // Block dimensions
   localparam int AXES      = 3;
   localparam int VEL_WIDTH = 16;

   // Fixed field and register widths
   localparam int FIELD_W   = 16;
   localparam int LANE_W    = 16;
   localparam int CFG_W     = 48;
   localparam int REG_LANES = CFG_W / LANE_W;
   localparam int AGE_W     = 16;
   localparam int CSR_IDX_W = 3;

   // Lane arithmetic width: holds a velocity difference and a full 16-bit step
   localparam int CALC_W = ((VEL_WIDTH > LANE_W) ? VEL_WIDTH : LANE_W) + 2;

   localparam logic signed [CALC_W-1:0] VEL_MAX = CALC_W'((2 ** (VEL_WIDTH - 1)) - 1);
   localparam logic signed [CALC_W-1:0] VEL_MIN = CALC_W'(-(2 ** (VEL_WIDTH - 1)));

   localparam logic [AGE_W-1:0] AGE_MAX = {AGE_W{1'b1}};

   // Item kinds
   localparam logic CMD_COMMAND = 1'b0;
   localparam logic CMD_TICK    = 1'b1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_ACCEL   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DECEL   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_UPPER   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LOWER   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_DBAND   = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT = 3'd5;

   // Register reset values
   localparam logic [CFG_W-1:0] ACCEL_RST   = 48'd85899345940;
   localparam logic [CFG_W-1:0] DECEL_RST   = 48'd429496730600;
   localparam logic [CFG_W-1:0] UPPER_RST   = 48'd2147483650000;
   localparam logic [CFG_W-1:0] LOWER_RST   = 48'd278039002938892;
   localparam logic [CFG_W-1:0] DBAND_RST   = 48'd0;
   localparam logic [AGE_W-1:0] TIMEOUT_RST = 16'd20;

   typedef struct packed {
      logic                      cmd;
      logic signed [FIELD_W-1:0] target_x;
      logic signed [FIELD_W-1:0] target_y;
      logic signed [FIELD_W-1:0] target_yaw;
   } req_payload_type;

   typedef struct packed {
      logic signed [FIELD_W-1:0] vel_x;
      logic signed [FIELD_W-1:0] vel_y;
      logic signed [FIELD_W-1:0] vel_yaw;
      logic                      timed_out;
   } rsp_payload_type;

   // Per-axis configuration slice
   typedef struct packed {
      logic [LANE_W-1:0]        accel;
      logic [LANE_W-1:0]        decel;
      logic signed [LANE_W-1:0] upper;
      logic signed [LANE_W-1:0] lower;
      logic [LANE_W-1:0]        deadband;
   } lane_cfg_type;

   // Per-item lane control
   typedef struct packed {
      logic load;
      logic step;
      logic stale;
   } lane_ctrl_type;

   typedef logic [AXES-1:0][VEL_WIDTH-1:0] vel_vec_type;

   // Sign-extend one lane's velocity to a result field, zero for absent axes
   function automatic logic signed [FIELD_W-1:0] pick_vel(input vel_vec_type vel, input int idx);
      logic signed [FIELD_W-1:0] res;
      res = '0;
      for (int a = 0; a < AXES; a++) begin
         if (a == idx) begin
            res = FIELD_W'($signed(vel[a]));
         end
      end
      return res;
   endfunction

endpackage

>>> hdl/vsl_lane.sv
// One axis of the slew limiter: stored target, current velocity and the
// step / clamp / deadband update. Depends on vsl_pkg.
`timescale 1ns / 1ps

module vsl_lane (
   input  logic                                     clock,
   input  logic                                     reset,
   input  vsl_pkg::lane_cfg_type                    cfg,
   input  vsl_pkg::lane_ctrl_type                   ctrl,
   input  logic signed [vsl_pkg::VEL_WIDTH-1:0]     target_in,
   output logic signed [vsl_pkg::VEL_WIDTH-1:0]     vel
);

   logic signed [vsl_pkg::VEL_WIDTH-1:0] cur_ff, cur_in;
   logic signed [vsl_pkg::VEL_WIDTH-1:0] tgt_ff, tgt_in;

   logic signed [vsl_pkg::CALC_W-1:0] cur_w, tgt_w, dv, up_w, dn_w, hi_w, lo_w, db_w;
   logic signed [vsl_pkg::CALC_W-1:0] moved, clamped, mag;
   logic signed [vsl_pkg::CALC_W-1:0] cur_mag;

   // Widen operands
   assign cur_w = vsl_pkg::CALC_W'(cur_ff);
   assign tgt_w = ctrl.stale ? '0 : vsl_pkg::CALC_W'(tgt_ff);
   assign dv    = tgt_w - cur_w;
   assign up_w  = $signed(vsl_pkg::CALC_W'(cfg.accel));
   assign dn_w  = $signed(vsl_pkg::CALC_W'(cfg.decel));
   assign hi_w  = vsl_pkg::CALC_W'(cfg.upper);
   assign lo_w  = vsl_pkg::CALC_W'(cfg.lower);
   assign db_w  = $signed(vsl_pkg::CALC_W'(cfg.deadband));

   // Step toward the target, limited by the rise or fall step; a zero step jumps to it
   always_comb begin
      if (cfg.accel == '0 || cfg.decel == '0) begin
         moved = tgt_w;
      end else if (dv > 0) begin
         moved = cur_w + ((dv < up_w) ? dv : up_w);
      end else if (dv < 0) begin
         moved = cur_w + ((dv > -dn_w) ? dv : -dn_w);
      end else begin
         moved = cur_w;
      end
   end

   // Clamp to the axis limits (lower wins), then to the velocity range
   always_comb begin
      clamped = moved;
      if (clamped > hi_w) clamped = hi_w;
      if (clamped < lo_w) clamped = lo_w;
      if (clamped > vsl_pkg::VEL_MAX) clamped = vsl_pkg::VEL_MAX;
      if (clamped < vsl_pkg::VEL_MIN) clamped = vsl_pkg::VEL_MIN;
   end

   // Drop values inside the deadband
   assign mag = (clamped < 0) ? -clamped : clamped;

   always_comb begin
      cur_in = cur_ff;
      if (ctrl.step) begin
         cur_in = (mag < db_w) ? '0 : clamped[vsl_pkg::VEL_WIDTH-1:0];
      end
   end

   assign tgt_in = ctrl.load ? target_in : tgt_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff <= '0;
         tgt_ff <= '0;
      end else begin
         cur_ff <= cur_in;
         tgt_ff <= tgt_in;
      end
   end

   assign vel = cur_in;

   assign cur_mag = (cur_ff < 0) ? -vsl_pkg::CALC_W'(cur_ff) : vsl_pkg::CALC_W'(cur_ff);

   a_deadband_respected: assert property (@(posedge clock) disable iff (reset)
      ctrl.step |=> (cur_ff == '0 ||
                     cur_mag >= $signed(vsl_pkg::CALC_W'($past(cfg.deadband)))))
      else $error("velocity left inside the deadband");

   a_target_loaded: assert property (@(posedge clock) disable iff (reset)
      ctrl.load |=> tgt_ff == $past(target_in))
      else $error("command target not stored");

   a_hold_when_idle: assert property (@(posedge clock) disable iff (reset)
      !ctrl.step |=> cur_ff == $past(cur_ff))
      else $error("velocity changed without a tick");

endmodule

>>> hdl/vsl_rsp_buf.sv
// Merges the lane velocities into a result and holds it in an output
// register with a skid stage. Depends on vsl_pkg.
`timescale 1ns / 1ps

module vsl_rsp_buf (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     produce,
   input  vsl_pkg::vel_vec_type     vel,
   input  logic                     timed_out,
   output logic                     full,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output vsl_pkg::rsp_payload_type rsp_payload
);

   vsl_pkg::rsp_payload_type merged;
   vsl_pkg::rsp_payload_type out_ff, out_in, skid_ff, skid_in;
   logic out_valid_ff, out_valid_in, skid_valid_ff, skid_valid_in;
   logic take;

   // Combine the lanes into one result
   always_comb begin
      merged.vel_x     = vsl_pkg::pick_vel(vel, 0);
      merged.vel_y     = vsl_pkg::pick_vel(vel, 1);
      merged.vel_yaw   = vsl_pkg::pick_vel(vel, 2);
      merged.timed_out = timed_out;
   end

   assign take = out_valid_ff && !rsp_stall;

   // Advance the skid into the output register, or park a new result
   always_comb begin
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (take || !out_valid_ff) begin
         out_in        = skid_valid_ff ? skid_ff : merged;
         out_valid_in  = skid_valid_ff || produce;
         skid_valid_in = 1'b0;
      end else if (produce) begin
         skid_in       = merged;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign full        = skid_valid_ff;
   assign rsp_valid   = out_valid_ff;
   assign rsp_payload = out_ff;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid holds a result while the output is empty");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> !produce)
      else $error("result arrived while the skid was full");

   a_park_on_stall: assert property (@(posedge clock) disable iff (reset)
      (produce && out_valid_ff && rsp_stall) |=> skid_valid_ff)
      else $error("result lost on a stalled output");

endmodule

>>> hdl/velocity_slew_limiter_core.sv
// Velocity slew limiter top level: configuration registers, command age
// tracking, one vsl_lane per axis and the vsl_rsp_buf result stage.
// A tick's result is registered onto rsp_ (via skid under rsp_stall); commands give none.
// Throughput: 1 item per cycle unless req_stall; lanes update velocity in the transfer cycle.
// The skid stage lets one more tick in while a result waits under rsp_stall.
// Reset (synchronous) clears velocities, targets, command age and loads register defaults.
`timescale 1ns / 1ps

module velocity_slew_limiter_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  vsl_pkg::req_payload_type            req_payload,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output vsl_pkg::rsp_payload_type            rsp_payload,
   input  logic                                csr_wen,
   input  logic [vsl_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [vsl_pkg::CFG_W-1:0]           csr_wdata
);

   logic [vsl_pkg::CFG_W-1:0] accel_ff, accel_in, decel_ff, decel_in;
   logic [vsl_pkg::CFG_W-1:0] upper_ff, upper_in, lower_ff, lower_in;
   logic [vsl_pkg::CFG_W-1:0] dband_ff, dband_in;
   logic [vsl_pkg::AGE_W-1:0] timeout_ff, timeout_in;

   logic                      seen_ff, seen_in;
   logic [vsl_pkg::AGE_W-1:0] age_ff, age_in;

   logic fire, is_cmd, is_tick, stale, buf_full;
   vsl_pkg::lane_ctrl_type ctrl;
   vsl_pkg::vel_vec_type   vel;

   // Register writes
   always_comb begin
      accel_in   = accel_ff;
      decel_in   = decel_ff;
      upper_in   = upper_ff;
      lower_in   = lower_ff;
      dband_in   = dband_ff;
      timeout_in = timeout_ff;
      if (csr_wen) begin
         unique case (csr_index)
            vsl_pkg::CSR_ACCEL:   accel_in   = csr_wdata;
            vsl_pkg::CSR_DECEL:   decel_in   = csr_wdata;
            vsl_pkg::CSR_UPPER:   upper_in   = csr_wdata;
            vsl_pkg::CSR_LOWER:   lower_in   = csr_wdata;
            vsl_pkg::CSR_DBAND:   dband_in   = csr_wdata;
            vsl_pkg::CSR_TIMEOUT: timeout_in = csr_wdata[vsl_pkg::AGE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accel_ff   <= vsl_pkg::ACCEL_RST;
         decel_ff   <= vsl_pkg::DECEL_RST;
         upper_ff   <= vsl_pkg::UPPER_RST;
         lower_ff   <= vsl_pkg::LOWER_RST;
         dband_ff   <= vsl_pkg::DBAND_RST;
         timeout_ff <= vsl_pkg::TIMEOUT_RST;
      end else begin
         accel_ff   <= accel_in;
         decel_ff   <= decel_in;
         upper_ff   <= upper_in;
         lower_ff   <= lower_in;
         dband_ff   <= dband_in;
         timeout_ff <= timeout_in;
      end
   end

   // Input transfer decode
   assign req_stall = buf_full;
   assign fire      = req_valid && !req_stall;
   assign is_cmd    = fire && (req_payload.cmd == vsl_pkg::CMD_COMMAND);
   assign is_tick   = fire && (req_payload.cmd == vsl_pkg::CMD_TICK);

   // Staleness uses the age found before this tick counts
   assign stale = !seen_ff || (age_ff > timeout_ff);

   always_comb begin
      seen_in = seen_ff;
      age_in  = age_ff;
      if (is_cmd) begin
         seen_in = 1'b1;
         age_in  = '0;
      end else if (is_tick && age_ff != vsl_pkg::AGE_MAX) begin
         age_in = age_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff <= 1'b0;
         age_ff  <= '0;
      end else begin
         seen_ff <= seen_in;
         age_ff  <= age_in;
      end
   end

   assign ctrl.load  = is_cmd;
   assign ctrl.step  = is_tick;
   assign ctrl.stale = stale;

   // One lane per axis
   for (genvar a = 0; a < vsl_pkg::AXES; a++) begin : g_lane
      vsl_pkg::lane_cfg_type                   lane_cfg;
      logic signed [vsl_pkg::VEL_WIDTH-1:0]    lane_tgt;
      logic signed [vsl_pkg::VEL_WIDTH-1:0]    lane_vel;

      if (a < vsl_pkg::REG_LANES) begin : g_cfg
         assign lane_cfg.accel    = accel_ff[a*vsl_pkg::LANE_W +: vsl_pkg::LANE_W];
         assign lane_cfg.decel    = decel_ff[a*vsl_pkg::LANE_W +: vsl_pkg::LANE_W];
         assign lane_cfg.upper    = upper_ff[a*vsl_pkg::LANE_W +: vsl_pkg::LANE_W];
         assign lane_cfg.lower    = lower_ff[a*vsl_pkg::LANE_W +: vsl_pkg::LANE_W];
         assign lane_cfg.deadband = dband_ff[a*vsl_pkg::LANE_W +: vsl_pkg::LANE_W];
      end else begin : g_cfg_none
         assign lane_cfg = '0;
      end

      if (a == 0) begin : g_tx
         assign lane_tgt = req_payload.target_x[vsl_pkg::VEL_WIDTH-1:0];
      end else if (a == 1) begin : g_ty
         assign lane_tgt = req_payload.target_y[vsl_pkg::VEL_WIDTH-1:0];
      end else if (a == 2) begin : g_tyaw
         assign lane_tgt = req_payload.target_yaw[vsl_pkg::VEL_WIDTH-1:0];
      end else begin : g_tnone
         assign lane_tgt = '0;
      end

      vsl_lane u_lane (
         .clock     (clock),
         .reset     (reset),
         .cfg       (lane_cfg),
         .ctrl      (ctrl),
         .target_in (lane_tgt),
         .vel       (lane_vel)
      );

      assign vel[a] = lane_vel;
   end

   vsl_rsp_buf u_rsp_buf (
      .clock       (clock),
      .reset       (reset),
      .produce     (is_tick),
      .vel         (vel),
      .timed_out   (stale),
      .full        (buf_full),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   a_cmd_resets_age: assert property (@(posedge clock) disable iff (reset)
      is_cmd |=> (age_ff == '0 && seen_ff))
      else $error("command did not restart the age count");

   a_tick_gives_result: assert property (@(posedge clock) disable iff (reset)
      is_tick |=> rsp_valid)
      else $error("tick produced no pending result");

   a_age_moves_on_tick: assert property (@(posedge clock) disable iff (reset)
      (!fire && !$past(reset)) |-> (age_ff == $past(age_ff) || $past(fire)))
      else $error("command age changed without a transfer");

endmodule
